// File: sv/vr_pkg.sv
// Package for the vector refraction block: fixed-point constants, internal widths
// and the item type that travels from the front end through the queue.
// No dependencies.
package vr_pkg;

   localparam int FRAC_BITS = 14;

   // Widths follow from 16-bit Q2.14 operands and a 16-bit unsigned ratio.
   localparam int COMP_W = 16;
   localparam int PROD_W = 18;           // floored product of two components
   localparam int C_W    = 20;           // cosine term, signed
   localparam int S_W    = 20;           // d + c*n, signed
   localparam int Q_W    = 22;           // perpendicular component, signed
   localparam int SQ_W   = 28;           // one floored square
   localparam int M_W    = 30;           // sum of squares and radicand magnitude
   localparam int V_W    = M_W + FRAC_BITS;
   localparam int ROOT_W = V_W / 2;
   localparam int PAR_W  = 24;           // parallel component, signed
   localparam int OUT_W  = 25;           // unsaturated output, signed

   localparam logic signed [C_W-1:0] ONE_C = C_W'(1) <<< FRAC_BITS;

   typedef logic signed [COMP_W-1:0] comp_type;

   typedef struct packed {
      comp_type                dir_x;
      comp_type                dir_y;
      comp_type                dir_z;
      comp_type                norm_x;
      comp_type                norm_y;
      comp_type                norm_z;
      logic [COMP_W-1:0]       index_ratio;
      logic signed [C_W-1:0]   cosine;
   } vr_item_type;

endpackage

// File: sv/vr_req_if.sv
// Request channel of the vector refraction block: valid/ready plus payload.
// No dependencies.
interface vr_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] dir_x;
   logic signed [15:0] dir_y;
   logic signed [15:0] dir_z;
   logic signed [15:0] norm_x;
   logic signed [15:0] norm_y;
   logic signed [15:0] norm_z;
   logic [15:0]        index_ratio;

   modport source (output valid, dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, index_ratio,
                   input ready);
   modport sink   (input valid, dir_x, dir_y, dir_z, norm_x, norm_y, norm_z, index_ratio,
                   output ready);
endinterface

// File: sv/vr_rsp_if.sv
// Response channel of the vector refraction block: valid/ready plus payload.
// No dependencies.
interface vr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] out_x;
   logic signed [15:0] out_y;
   logic signed [15:0] out_z;
   logic               clipped;

   modport source (output valid, out_x, out_y, out_z, clipped, input ready);
   modport sink   (input valid, out_x, out_y, out_z, clipped, output ready);
endinterface

// File: sv/vector_refract.sv
// Vector refraction block: top level joining front end, queue and pipeline.
// Depends on vr_pkg, vr_req_if, vr_rsp_if, vr_front, vr_queue and vr_back.
//
// Usage: each req transfer carries an incident direction, a surface normal
// (signed Q2.14) and an index ratio (unsigned Q2.14). Each rsp transfer
// returns the refracted direction, saturated to 16 bits, with clipped set
// when any component was clamped. Results come back in request order.
// Throughput is one transfer per cycle in each direction while the receiver
// does not stall. An unstalled request passes these registers in order: the
// transfer edge itself registers the dot products in the front end, the item
// is then written into the queue, then come four arithmetic stages, one stage
// per bit of the square root (22 stages) and two output stages. The root
// chain is the longest part of that path.
// When the receiver stalls, the arithmetic pipeline holds as a whole, the
// queue of QUEUE_DEPTH entries fills and the front end keeps taking
// requests until the queue is full, after which req.ready falls.
// Synchronous reset empties the queue and the pipeline; no results are
// pending afterwards, and there is no clearing pass.
module vector_refract #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic  clock,
   input  logic  reset,
   vr_req_if.sink   req,
   vr_rsp_if.source rsp
);
   import vr_pkg::*;

   vr_item_type push_item, pop_item;
   logic        push, push_ready, pop, pop_avail;

   vr_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .push       (push),
      .push_item  (push_item),
      .push_ready (push_ready)
   );

   // The queue lets the front end keep accepting while the pipeline stalls.
   vr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_item   (pop_item),
      .pop_avail  (pop_avail)
   );

   vr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_item  (pop_item),
      .pop_avail (pop_avail),
      .pop       (pop),
      .rsp       (rsp)
   );

endmodule

// File: sv/vr_front.sv
// Front end of the vector refraction block: takes requests, forms the dot
// product and the clamped cosine. Depends on vr_pkg and vr_req_if.
module vr_front (
   input  logic                clock,
   input  logic                reset,
   vr_req_if.sink              req,
   output logic                push,
   output vr_pkg::vr_item_type push_item,
   input  logic                push_ready
);
   import vr_pkg::*;

   logic                     valid_ff, valid_in;
   vr_item_type              item_ff, item_in;
   logic signed [PROD_W-1:0] prod_ff [3];
   logic signed [PROD_W-1:0] prod_in [3];
   logic signed [31:0]       mul [3];
   logic signed [C_W-1:0]    dot;
   logic signed [C_W-1:0]    neg_dot;
   logic                     take;

   assign req.ready = !valid_ff || push_ready;
   assign take      = req.valid && req.ready;

   assign mul[0] = 32'(req.dir_x) * 32'(req.norm_x);
   assign mul[1] = 32'(req.dir_y) * 32'(req.norm_y);
   assign mul[2] = 32'(req.dir_z) * 32'(req.norm_z);

   always_comb begin
      valid_in = req.ready ? req.valid : valid_ff;
      item_in  = item_ff;
      for (int i = 0; i < 3; i++) begin
         prod_in[i] = take ? PROD_W'(mul[i] >>> FRAC_BITS) : prod_ff[i];
      end
      if (take) begin
         item_in.dir_x       = req.dir_x;
         item_in.dir_y       = req.dir_y;
         item_in.dir_z       = req.dir_z;
         item_in.norm_x      = req.norm_x;
         item_in.norm_y      = req.norm_y;
         item_in.norm_z      = req.norm_z;
         item_in.index_ratio = req.index_ratio;
         item_in.cosine      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
      prod_ff <= prod_in;
   end

   // The cosine saturates at 1.0 from above only.
   always_comb begin
      dot     = C_W'(prod_ff[0]) + C_W'(prod_ff[1]) + C_W'(prod_ff[2]);
      neg_dot = -dot;
      push_item        = item_ff;
      push_item.cosine = (neg_dot > ONE_C) ? ONE_C : neg_dot;
   end

   assign push = valid_ff;

endmodule

// File: sv/vr_queue.sv
// Short queue between the front end and the arithmetic pipeline.
// Depends on vr_pkg.
module vr_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  vr_pkg::vr_item_type push_item,
   output logic                push_ready,
   input  logic                pop,
   output vr_pkg::vr_item_type pop_item,
   output logic                pop_avail
);
   import vr_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   vr_item_type        mem_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign push_ready = count_ff != CNT_W'(DEPTH);
   assign pop_avail  = count_ff != '0;
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_avail;
   assign pop_item   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: sv/vr_back.sv
// Arithmetic pipeline of the vector refraction block: perpendicular part,
// squared length, bit-per-stage square root, output. Depends on vr_pkg, vr_rsp_if.
module vr_back (
   input  logic                clock,
   input  logic                reset,
   input  vr_pkg::vr_item_type pop_item,
   input  logic                pop_avail,
   output logic                pop,
   vr_rsp_if.source            rsp
);
   import vr_pkg::*;

   localparam int NS = ROOT_W;

   logic en;

   // Stage 1: s = d + floor(c*n)
   logic                    v1_ff;
   logic signed [S_W-1:0]   s1_ff [3];
   comp_type                n1_ff [3];
   logic [COMP_W-1:0]       eta1_ff;
   comp_type                d0 [3];
   comp_type                n0 [3];
   logic signed [35:0]      cn_mul [3];
   logic signed [S_W-1:0]   s1_in [3];

   // Stage 2: q = floor(eta*s)
   logic                    v2_ff;
   logic signed [Q_W-1:0]   q2_ff [3];
   comp_type                n2_ff [3];
   logic signed [36:0]      eq_mul [3];

   // Stage 3: floored squares
   logic                    v3_ff;
   logic [SQ_W-1:0]         sq3_ff [3];
   logic signed [Q_W-1:0]   q3_ff [3];
   comp_type                n3_ff [3];
   logic [Q_W-1:0]          mag [3];
   logic [2*Q_W-1:0]        mag_sq [3];

   // Root stages: index 0 holds the radicand, index NS the finished root
   logic                    vr_ff   [NS+1];
   logic [V_W+1:0]          rem_ff  [NS+1];
   logic [ROOT_W-1:0]       root_ff [NS+1];
   logic signed [Q_W-1:0]   qr_ff   [NS+1][3];
   comp_type                nr_ff   [NS+1][3];
   logic [M_W-1:0]          m2;
   logic signed [M_W+1:0]   rad_s;
   logic [M_W-1:0]          rad_abs;

   // Stage 5: parallel part
   logic                    v5_ff;
   logic signed [PAR_W-1:0] par5_ff [3];
   logic signed [Q_W-1:0]   q5_ff [3];
   logic signed [40:0]      par_mul [3];

   // Output register
   logic                    vo_ff;
   logic signed [OUT_W-1:0] sum [3];
   comp_type                sat [3];
   logic [2:0]              clip;

   assign en  = !vo_ff || rsp.ready;
   assign pop = en && pop_avail;

   assign d0[0] = pop_item.dir_x;
   assign d0[1] = pop_item.dir_y;
   assign d0[2] = pop_item.dir_z;
   assign n0[0] = pop_item.norm_x;
   assign n0[1] = pop_item.norm_y;
   assign n0[2] = pop_item.norm_z;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cn_mul[i] = 36'(pop_item.cosine) * 36'(n0[i]);
         s1_in[i]  = S_W'(d0[i]) + S_W'(cn_mul[i] >>> FRAC_BITS);
         eq_mul[i] = 37'(signed'({1'b0, eta1_ff})) * 37'(s1_ff[i]);
         mag[i]    = q2_ff[i][Q_W-1] ? Q_W'(-q2_ff[i]) : Q_W'(q2_ff[i]);
         mag_sq[i] = (2*Q_W)'(mag[i]) * (2*Q_W)'(mag[i]);
      end
      m2      = M_W'(sq3_ff[0]) + M_W'(sq3_ff[1]) + M_W'(sq3_ff[2]);
      rad_s   = (M_W+2)'(ONE_C) - (M_W+2)'(m2);
      rad_abs = rad_s[M_W+1] ? M_W'(-rad_s) : M_W'(rad_s);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         vr_ff[0]  <= 1'b0;
      end else if (en) begin
         v1_ff     <= pop_avail;
         v2_ff     <= v1_ff;
         v3_ff     <= v2_ff;
         vr_ff[0]  <= v3_ff;
      end
      if (en) begin
         eta1_ff <= pop_item.index_ratio;
         for (int i = 0; i < 3; i++) begin
            s1_ff[i]     <= s1_in[i];
            n1_ff[i]     <= n0[i];
            q2_ff[i]     <= Q_W'(eq_mul[i] >>> FRAC_BITS);
            n2_ff[i]     <= n1_ff[i];
            sq3_ff[i]    <= SQ_W'(mag_sq[i] >> FRAC_BITS);
            q3_ff[i]     <= q2_ff[i];
            n3_ff[i]     <= n2_ff[i];
            qr_ff[0][i]  <= q3_ff[i];
            nr_ff[0][i]  <= n3_ff[i];
         end
         rem_ff[0]  <= (V_W+2)'({rad_abs, {FRAC_BITS{1'b0}}});
         root_ff[0] <= '0;
      end
   end

   // One result bit per stage, most significant first.
   for (genvar k = 1; k <= NS; k++) begin : g_root
      localparam int B = NS - k;
      logic [V_W+1:0]    trial;
      logic              fits;

      assign trial = ((V_W+2)'(root_ff[k-1]) << (B + 1)) + ((V_W+2)'(1) << (2 * B));
      assign fits  = rem_ff[k-1] >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            vr_ff[k] <= 1'b0;
         end else if (en) begin
            vr_ff[k] <= vr_ff[k-1];
         end
         if (en) begin
            rem_ff[k]  <= fits ? rem_ff[k-1] - trial : rem_ff[k-1];
            root_ff[k] <= fits ? (root_ff[k-1] | (ROOT_W'(1) << B)) : root_ff[k-1];
            qr_ff[k]   <= qr_ff[k-1];
            nr_ff[k]   <= nr_ff[k-1];
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         par_mul[i] = -(41'(signed'({1'b0, root_ff[NS]})) * 41'(nr_ff[NS][i]));
         sum[i]     = OUT_W'(q5_ff[i]) + OUT_W'(par5_ff[i]);
         if (sum[i] > OUT_W'(32767)) begin
            sat[i]  = 16'sh7FFF;
            clip[i] = 1'b1;
         end else if (sum[i] < -OUT_W'(32768)) begin
            sat[i]  = -16'sh8000;
            clip[i] = 1'b1;
         end else begin
            sat[i]  = COMP_W'(sum[i]);
            clip[i] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else if (en) begin
         v5_ff <= vr_ff[NS];
         vo_ff <= v5_ff;
      end
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            par5_ff[i] <= PAR_W'(par_mul[i] >>> FRAC_BITS);
            q5_ff[i]   <= qr_ff[NS][i];
         end
         rsp.out_x   <= sat[0];
         rsp.out_y   <= sat[1];
         rsp.out_z   <= sat[2];
         rsp.clipped <= |clip;
      end
   end

   assign rsp.valid = vo_ff;

endmodule

// File: tb/tb_vector_refract.sv
// Self-checking testbench for the vector refraction block: directed and random
// queries, random stalls on both channels, results checked against a predictor.
// Depends on vr_pkg, vr_req_if, vr_rsp_if and vector_refract.
module tb_vector_refract;
   timeunit 1ns;
   timeprecision 1ps;

   import vr_pkg::*;

   localparam int RANDOM_QUERIES = 930;
   localparam int STALL_LIMIT    = 2000;   // cycles with no transfer on either side
   localparam int DRAIN_CYCLES   = 40;     // a little over the block's latency

   typedef struct {
      comp_type    dir_x, dir_y, dir_z;
      comp_type    norm_x, norm_y, norm_z;
      logic [15:0] index_ratio;
   } query_type;

   typedef struct {
      comp_type out_x, out_y, out_z;
      logic     clipped;
   } refraction_type;

   // The scoreboard holds the refracted directions still owed by the block and
   // works each one out as soon as its query has been accepted.
   class refraction_scoreboard;
      refraction_type pending_refractions[$];
      int             mismatches;
      int             checked;
      int             clip_count;

      function automatic longint floor_frac(longint v);
         return v >>> FRAC_BITS;
      endfunction

      function automatic longint unsigned int_sqrt(longint unsigned v);
         longint unsigned r, b;
         r = 0;
         b = 64'd1 << 62;
         while (b > v) b >>= 2;
         while (b != 0) begin
            if (v >= r + b) begin
               v -= r + b;
               r = (r >> 1) + b;
            end else begin
               r >>= 1;
            end
            b >>= 2;
         end
         return r;
      endfunction

      function automatic comp_type clamp16(longint v, ref logic clip);
         if (v > 32767) begin
            clip = 1'b1;
            return 16'sh7fff;
         end
         if (v < -32768) begin
            clip = 1'b1;
            return 16'sh8000;
         end
         return comp_type'(v);
      endfunction

      // Snell refraction in vector form with every product floored by the
      // fraction width; the magnitude of the radicand is taken as it stands.
      function automatic refraction_type refract(query_type q);
         longint          d[3], n[3], p[3];
         longint          one, eta, dp, c, m2, rad, s, t;
         longint unsigned mag, root;
         logic            clip;
         refraction_type  r;
         one  = longint'(1) << FRAC_BITS;
         eta  = longint'(q.index_ratio);
         clip = 1'b0;
         d[0] = q.dir_x;  d[1] = q.dir_y;  d[2] = q.dir_z;
         n[0] = q.norm_x; n[1] = q.norm_y; n[2] = q.norm_z;
         dp = floor_frac(d[0] * n[0]) + floor_frac(d[1] * n[1]) + floor_frac(d[2] * n[2]);
         c  = -dp;
         if (c > one) c = one;
         m2 = 0;
         for (int i = 0; i < 3; i++) begin
            s = d[i] + floor_frac(c * n[i]);
            t = floor_frac(eta * s);
            // Never reached at fourteen fraction bits, kept for completeness.
            if (t > 64'sd2147483647) begin
               t = 64'sd2147483647;
               clip = 1'b1;
            end
            if (t < -64'sd2147483648) begin
               t = -64'sd2147483648;
               clip = 1'b1;
            end
            p[i] = t;
            mag  = (t < 0) ? longint'(-t) : longint'(t);
            m2  += longint'((mag * mag) >> FRAC_BITS);
         end
         rad = one - m2;
         if (rad < 0) rad = -rad;
         root = int_sqrt(longint'(rad) << FRAC_BITS);
         r.out_x   = clamp16(p[0] + floor_frac(-longint'(root) * n[0]), clip);
         r.out_y   = clamp16(p[1] + floor_frac(-longint'(root) * n[1]), clip);
         r.out_z   = clamp16(p[2] + floor_frac(-longint'(root) * n[2]), clip);
         r.clipped = clip;
         return r;
      endfunction

      function void note_query(query_type q);
         pending_refractions.push_back(refract(q));
      endfunction

      function void check_refraction(refraction_type got);
         refraction_type exp_r;
         checked++;
         if (got.clipped) clip_count++;
         if (pending_refractions.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected result x=%0d y=%0d z=%0d clipped=%0b",
                        got.out_x, got.out_y, got.out_z, got.clipped);
            return;
         end
         exp_r = pending_refractions.pop_front();
         if (got.out_x !== exp_r.out_x || got.out_y !== exp_r.out_y ||
             got.out_z !== exp_r.out_z || got.clipped !== exp_r.clipped) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("ERROR: result %0d expected x=%0d y=%0d z=%0d clipped=%0b,",
                        checked, exp_r.out_x, exp_r.out_y, exp_r.out_z, exp_r.clipped);
               $display("       got x=%0d y=%0d z=%0d clipped=%0b",
                        got.out_x, got.out_y, got.out_z, got.clipped);
            end
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   vr_req_if req ();
   vr_rsp_if rsp ();

   vector_refract u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   refraction_scoreboard refraction_board = new();
   query_type            query_list[$];
   bit                   stimulus_done;
   bit                   sink_no_stall;   // stretches where the receiver never stalls
   int                   idle_cycles;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Every accepted query is predicted at once; every accepted result is
   // checked against the oldest prediction still outstanding.
   always @(posedge clock) begin
      if (!reset && req.valid && req.ready)
         refraction_board.note_query('{req.dir_x, req.dir_y, req.dir_z,
                                       req.norm_x, req.norm_y, req.norm_z,
                                       req.index_ratio});
      if (!reset && rsp.valid && rsp.ready)
         refraction_board.check_refraction('{rsp.out_x, rsp.out_y, rsp.out_z, rsp.clipped});
   end

   // Watchdog: a run in which nothing moves for too long is a hung block.
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("ERROR: no transfer for %0d cycles, %0d results outstanding",
                  STALL_LIMIT, refraction_board.pending_refractions.size());
         $display("** vector_refract: FAILED **");
         $finish;
      end
   end

   function automatic query_type make_query(int dx, int dy, int dz, int nx, int ny, int nz,
                                            int eta);
      query_type q;
      q.dir_x  = comp_type'(dx); q.dir_y  = comp_type'(dy); q.dir_z  = comp_type'(dz);
      q.norm_x = comp_type'(nx); q.norm_y = comp_type'(ny); q.norm_z = comp_type'(nz);
      q.index_ratio = 16'(eta);
      return q;
   endfunction

   // Mostly physically sensible queries (components between -1.0 and 1.0, ratios
   // from 0.5 to 2.0), with a share of full-range noise to reach every bit.
   function automatic query_type random_query();
      query_type q;
      if ($urandom_range(0, 3) == 0) begin
         q.dir_x  = comp_type'($urandom); q.dir_y  = comp_type'($urandom);
         q.dir_z  = comp_type'($urandom); q.norm_x = comp_type'($urandom);
         q.norm_y = comp_type'($urandom); q.norm_z = comp_type'($urandom);
         q.index_ratio = 16'($urandom);
      end else begin
         q.dir_x  = comp_type'(int'($urandom_range(0, 32768)) - 16384);
         q.dir_y  = comp_type'(int'($urandom_range(0, 32768)) - 16384);
         q.dir_z  = comp_type'(int'($urandom_range(0, 32768)) - 16384);
         q.norm_x = comp_type'(int'($urandom_range(0, 32768)) - 16384);
         q.norm_y = comp_type'(int'($urandom_range(0, 32768)) - 16384);
         q.norm_z = comp_type'(int'($urandom_range(0, 32768)) - 16384);
         q.index_ratio = 16'($urandom_range(8192, 32768));
      end
      return q;
   endfunction

   // Presents each query after a random gap; valid is only lowered when a
   // gap actually follows, so it never drops and rises in one time step.
   task automatic send_queries();
      int gap;
      foreach (query_list[i]) begin
         gap = ((i / 100) % 3 == 1) ? 0 : $urandom_range(0, 9);
         if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req.valid       <= 1'b1;
         req.dir_x       <= query_list[i].dir_x;
         req.dir_y       <= query_list[i].dir_y;
         req.dir_z       <= query_list[i].dir_z;
         req.norm_x      <= query_list[i].norm_x;
         req.norm_y      <= query_list[i].norm_y;
         req.norm_z      <= query_list[i].norm_z;
         req.index_ratio <= query_list[i].index_ratio;
         do @(posedge clock); while (!req.ready);
      end
      req.valid <= 1'b0;
   endtask

   // The receiver stalls randomly before each transfer, except in no-stall stretches.
   task automatic receive_results();
      int stall;
      forever begin
         stall = sink_no_stall ? 0 : $urandom_range(0, 9);
         if (stall > 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (!rsp.valid);
      end
   endtask

   initial begin
      int drain;
      reset           = 1'b1;
      req.valid       = 1'b0;
      req.dir_x       = '0;
      req.dir_y       = '0;
      req.dir_z       = '0;
      req.norm_x      = '0;
      req.norm_y      = '0;
      req.norm_z      = '0;
      req.index_ratio = '0;
      rsp.ready       = 1'b0;
      stimulus_done   = 1'b0;
      sink_no_stall   = 1'b0;

      // Directed queries: field extremes, normal and oblique incidence, the
      // cosine clamp, a negative radicand and output saturation.
      query_list.push_back(make_query(0, 0, 0, 0, 0, 0, 0));
      query_list.push_back(make_query(32767, 32767, 32767, 32767, 32767, 32767, 65535));
      query_list.push_back(make_query(-32768, -32768, -32768, -32768, -32768, -32768, 65535));
      query_list.push_back(make_query(32767, -32768, 32767, -32768, 32767, -32768, 65535));
      query_list.push_back(make_query(-32768, 32767, -32768, 32767, -32768, 32767, 0));
      query_list.push_back(make_query(0, 0, -16384, 0, 0, 16384, 16384));
      query_list.push_back(make_query(0, 0, -16384, 0, 0, 16384, 0));
      query_list.push_back(make_query(11585, 0, -11585, 0, 0, 16384, 16384));
      query_list.push_back(make_query(11585, 0, -11585, 0, 0, 16384, 12288));
      query_list.push_back(make_query(11585, 0, -11585, 0, 0, 16384, 24576));
      query_list.push_back(make_query(16000, 0, -3000, 0, 0, 16384, 32768));
      query_list.push_back(make_query(0, -32768, 0, 0, 32767, 0, 16384));
      query_list.push_back(make_query(-32768, 0, 0, 32767, 0, 0, 65535));
      query_list.push_back(make_query(9459, 9459, 9459, -9459, -9459, -9459, 20000));
      query_list.push_back(make_query(32767, 32767, 0, 0, -32768, 0, 65535));
      query_list.push_back(make_query(-16384, 0, 0, -16384, 0, 0, 16384));
      query_list.push_back(make_query(1, -1, 1, -1, 1, -1, 1));
      query_list.push_back(make_query(0, 16384, 0, 0, -32768, 0, 49152));
      for (int i = 0; i < RANDOM_QUERIES; i++)
         query_list.push_back(random_query());

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      fork
         receive_results();
         begin
            send_queries();
            stimulus_done = 1'b1;
         end
         // Switch the receiver between stalling and free-running stretches.
         while (!stimulus_done) begin
            repeat ($urandom_range(100, 400)) @(posedge clock);
            sink_no_stall = ($urandom_range(0, 2) == 0);
         end
      join_any
      wait (stimulus_done);
      sink_no_stall = 1'b0;

      wait (refraction_board.pending_refractions.size() == 0);
      drain = 0;
      while (drain < DRAIN_CYCLES) begin
         @(posedge clock);
         drain++;
      end

      $display("Sent %0d refraction queries (%0d directed), checked %0d results, %0d clipped.",
               query_list.size(), query_list.size() - RANDOM_QUERIES,
               refraction_board.checked, refraction_board.clip_count);
      if (refraction_board.mismatches > 0)
         $display("%0d mismatching results in total.", refraction_board.mismatches);
      if (refraction_board.mismatches == 0 && refraction_board.pending_refractions.size() == 0)
         $display("** vector_refract: PASSED **");
      else
         $display("** vector_refract: FAILED **");
      $finish;
   end

endmodule
